[sv/drs_pkg.sv]
`timescale 1ns / 1ps
package drs_pkg;

  localparam int MAX_LEN = 64;
  localparam int CNT_W   = $clog2(MAX_LEN + 1);

  typedef struct packed {
    logic signed [31:0] value;
    logic               last;
  } in_t;

  typedef struct packed {
    logic signed [31:0] sorted_value;
    logic               end_of_run;
    logic               overflow;
  } res_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               valid;
  } slot_t;

  typedef struct packed {
    logic ins;
    logic shift;
  } cell_ctl_t;

  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } state_e;

endpackage

[sv/descending_row_sorter_core.sv]
`timescale 1ns / 1ps
// channel   ports                 handshake
// input     in_i (value, last)    start high and busy low at the clock edge
// result    res_o (sorted_value,  strobe_o high with each result
//           end_of_run, overflow)
//
// Loading accepts one element per cycle: every cell compares the new value and
// the chain shifts right by one place behind the insertion point.
// An item with last starts a run of n results, one per cycle from cell 0,
// while the chain shifts left; busy stays high until the last of them.
// Reset clears the valid bit of every cell and the counters.
// Results are not stalled: each one is on res_o for exactly one cycle.
module descending_row_sorter_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  drs_pkg::in_t  in_i,
  output logic          busy,
  output logic          strobe_o,
  output drs_pkg::res_t res_o
);
  import drs_pkg::*;

  cell_ctl_t ctl;
  slot_t     slots [MAX_LEN];
  logic      gts   [MAX_LEN];
  logic      end_run;
  logic      ovf;

  drs_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .last_i   (in_i.last),
    .busy     (busy),
    .ctl_o    (ctl),
    .strobe_o (strobe_o),
    .end_o    (end_run),
    .ovf_o    (ovf)
  );

  for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
    slot_t left;
    slot_t right;
    logic  left_gt;
    if (i == 0) begin : g_head
      assign left    = '0;
      assign left_gt = 1'b0;
    end else begin : g_body
      assign left    = slots[i-1];
      assign left_gt = gts[i-1];
    end
    if (i == MAX_LEN - 1) begin : g_tail
      assign right = '0;
    end else begin : g_mid
      assign right = slots[i+1];
    end
    drs_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl),
      .x_i       (in_i.value),
      .left_i    (left),
      .left_gt_i (left_gt),
      .right_i   (right),
      .slot_o    (slots[i]),
      .gt_o      (gts[i])
    );
  end

  assign res_o.sorted_value = slots[0].value;
  assign res_o.end_of_run   = end_run;
  assign res_o.overflow     = ovf;

`ifndef SYNTHESIS
  a_strobe_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> busy)
    else $error("result strobe outside a run");

  a_run_cont : assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !res_o.end_of_run |=> strobe_o)
    else $error("run ended without end_of_run");

  a_run_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && res_o.end_of_run |=> !busy)
    else $error("busy held after final result");

  a_head_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> slots[0].valid)
    else $error("result taken from an empty cell");
`endif

endmodule

[sv/drs_cell.sv]
`timescale 1ns / 1ps
module drs_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  drs_pkg::cell_ctl_t ctl_i,
  input  logic signed [31:0] x_i,
  input  drs_pkg::slot_t     left_i,
  input  logic               left_gt_i,
  input  drs_pkg::slot_t     right_i,
  output drs_pkg::slot_t     slot_o,
  output logic               gt_o
);
  import drs_pkg::*;

  logic signed [31:0] value_q, value_d;
  logic               valid_q, valid_d;

  assign gt_o   = !valid_q || (x_i > value_q);
  assign slot_o = '{value: value_q, valid: valid_q};

  always_comb begin
    value_d = value_q;
    valid_d = valid_q;
    if (ctl_i.shift) begin
      value_d = right_i.value;
      valid_d = right_i.valid;
    end else if (ctl_i.ins) begin
      if (left_gt_i) begin
        value_d = left_i.value;
        valid_d = left_i.valid;
      end else if (gt_o) begin
        value_d = x_i;
        valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

[sv/drs_ctrl.sv]
`timescale 1ns / 1ps
module drs_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic               last_i,
  output logic               busy,
  output drs_pkg::cell_ctl_t ctl_o,
  output logic               strobe_o,
  output logic               end_o,
  output logic               ovf_o
);
  import drs_pkg::*;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] remain_q, remain_d;
  logic             ovf_seen_q, ovf_seen_d;
  logic             ovf_run_q, ovf_run_d;
  logic             full;
  logic             accept;

  assign full   = (count_q == CNT_W'(MAX_LEN));
  assign accept = start && (state_q == ST_LOAD);

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    remain_d   = remain_q;
    ovf_seen_d = ovf_seen_q;
    ovf_run_d  = ovf_run_q;
    unique case (state_q)
      ST_LOAD: begin
        if (accept) begin
          if (last_i) begin
            state_d    = ST_EMIT;
            remain_d   = full ? count_q : count_q + CNT_W'(1);
            ovf_run_d  = ovf_seen_q || full;
            count_d    = '0;
            ovf_seen_d = 1'b0;
          end else if (full) begin
            ovf_seen_d = 1'b1;
          end else begin
            count_d = count_q + CNT_W'(1);
          end
        end
      end
      ST_EMIT: begin
        remain_d = remain_q - CNT_W'(1);
        if (remain_q == CNT_W'(1)) begin
          state_d = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    busy      = 1'b0;
    ctl_o     = '0;
    strobe_o  = 1'b0;
    end_o     = 1'b0;
    ovf_o     = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        ctl_o.ins = accept && !full;
      end
      ST_EMIT: begin
        busy        = 1'b1;
        ctl_o.shift = 1'b1;
        strobe_o    = 1'b1;
        end_o       = (remain_q == CNT_W'(1));
        ovf_o       = ovf_run_q;
      end
      default: busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      count_q    <= '0;
      remain_q   <= '0;
      ovf_seen_q <= 1'b0;
      ovf_run_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      remain_q   <= remain_d;
      ovf_seen_q <= ovf_seen_d;
      ovf_run_q  <= ovf_run_d;
    end
  end

endmodule

[tb/sort_run_checker.sv]
`timescale 1ns / 1ps
module sort_run_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          busy_i,
  input  drs_pkg::in_t  in_i,
  input  logic          strobe_i,
  input  drs_pkg::res_t res_i,
  output int            fail_count_o,
  output int            pending_o
);
  import drs_pkg::*;

  logic signed [31:0] held_row [$];
  logic               dropped;
  res_t               expected_sorted [$];
  int                 mismatches = 0;

  assign fail_count_o = mismatches;

  task automatic flag_mismatch(input string what);
    $display("%0t sorter mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic queue_sorted_run();
    logic signed [31:0] row [$];
    logic signed [31:0] swap;
    res_t               r;
    row = held_row;
    for (int i = 0; i + 1 < row.size(); i++) begin
      for (int j = i + 1; j < row.size(); j++) begin
        if (row[j] > row[i]) begin
          swap   = row[i];
          row[i] = row[j];
          row[j] = swap;
        end
      end
    end
    foreach (row[k]) begin
      r.sorted_value = row[k];
      r.end_of_run   = (k == row.size() - 1);
      r.overflow     = dropped;
      expected_sorted.push_back(r);
    end
    held_row.delete();
    dropped = 1'b0;
  endtask

  task automatic absorb_element(input in_t item);
    if (held_row.size() < MAX_LEN) begin
      held_row.push_back(item.value);
    end else begin
      dropped = 1'b1;
    end
    if (item.last) begin
      queue_sorted_run();
    end
  endtask

  task automatic check_result(input res_t got);
    res_t want;
    if (expected_sorted.size() == 0) begin
      flag_mismatch($sformatf("unexpected result value %0d", got.sorted_value));
    end else begin
      want = expected_sorted.pop_front();
      if (got.sorted_value !== want.sorted_value)
        flag_mismatch($sformatf("sorted_value %0d, want %0d",
                                got.sorted_value, want.sorted_value));
      if (got.end_of_run !== want.end_of_run)
        flag_mismatch($sformatf("end_of_run %b, want %b", got.end_of_run, want.end_of_run));
      if (got.overflow !== want.overflow)
        flag_mismatch($sformatf("overflow %b, want %b", got.overflow, want.overflow));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_row.delete();
      expected_sorted.delete();
      dropped   = 1'b0;
      pending_o <= 0;
    end else begin
      if (strobe_i) begin
        check_result(res_i);
      end
      if (start_i && !busy_i) begin
        absorb_element(in_i);
      end
      pending_o <= expected_sorted.size();
    end
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
module testbench;
  import drs_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 80;

  logic  clk_i = 1'b0;
  logic  rst_ni;
  logic  start;
  in_t   in_i;
  logic  busy;
  logic  strobe_o;
  res_t  res_o;
  int    fail_count;
  int    pending;
  int    cycles = 0;
  int    idle_pct = 0;
  int    sent = 0;

  always #5 clk_i = ~clk_i;

  descending_row_sorter_core dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .in_i     (in_i),
    .busy     (busy),
    .strobe_o (strobe_o),
    .res_o    (res_o)
  );

  sort_run_checker sorted_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .in_i         (in_i),
    .strobe_i     (strobe_o),
    .res_i        (res_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[descending_row_sorter_core] ERROR");
      $finish;
    end
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 6) - 3;
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_element(input logic [31:0] value, input logic last);
    in_t item;
    item.value = value;
    item.last  = last;
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    in_i  <= item;
    do @(posedge clk_i); while (busy);
    sent++;
  endtask

  task automatic send_row(input int len);
    for (int k = 0; k < len; k++) begin
      send_element(pick_value(), k == len - 1);
    end
  endtask

  task automatic send_random_rows(input int target);
    while (sent < target) begin
      if ($urandom_range(0, 19) == 0) begin
        send_row($urandom_range(MAX_LEN - 4, MAX_LEN + 6));
      end else begin
        send_row($urandom_range(1, 10));
      end
    end
  endtask

  initial begin
    start  <= 1'b0;
    in_i   <= '0;
    rst_ni <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_element(32'h7FFF_FFFF, 1'b1);
    send_element(32'h8000_0000, 1'b1);
    send_element(32'd5, 1'b0);
    send_element(-32'sd5, 1'b0);
    send_element(32'h7FFF_FFFF, 1'b0);
    send_element(32'h8000_0000, 1'b0);
    send_element(32'hFFFF_FFFF, 1'b0);
    send_element(32'd0, 1'b0);
    send_element(32'd1, 1'b0);
    send_element(32'hFFFF_FFFF, 1'b1);
    send_element(32'd42, 1'b0);
    send_element(32'd42, 1'b1);
    send_element(32'h5555_5555, 1'b0);
    send_element(32'hAAAA_AAAA, 1'b1);
    send_element(32'd0, 1'b1);

    idle_pct = 18;
    send_row(MAX_LEN + 2);
    send_random_rows(95);

    idle_pct = 85;
    send_random_rows(125);

    idle_pct = 0;
    send_row(MAX_LEN);
    send_random_rows(210);

    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("[descending_row_sorter_core] OK");
    end else begin
      $display("[descending_row_sorter_core] ERROR");
    end
    $finish;
  end

endmodule

[descending_row_sorter_core.f]
sv/drs_pkg.sv
sv/drs_cell.sv
sv/drs_ctrl.sv
sv/descending_row_sorter_core.sv
tb/sort_run_checker.sv
tb/testbench.sv
